// ===== src/fvn_pkg.sv =====
`timescale 1ns / 1ps
// Package for the fractal value-noise height core: constants, register codes.
// No dependencies; used by every module of the block.
package fvn_pkg;

  localparam int DEF_MAX_OCTAVES = 8;
  localparam int DEF_FRAC_BITS   = 16;

  localparam int COORD_W = 32;
  localparam int FREQ_W  = 24;
  // coordinate times frequency, signed
  localparam int P_W     = COORD_W + FREQ_W + 1;

  localparam logic [31:0] HASH_MUL_X = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Z = 32'd668265263;
  localparam logic [31:0] HASH_MUL_S = 32'd362437;
  localparam logic [31:0] HASH_MIX   = 32'd1274126177;
  localparam logic [23:0] VALUE_MAX  = 24'hFFFFFF;
  localparam int          SEED_STEP  = 17;
  localparam logic [17:0] FADE_THREE = 18'd196608;

  // pipeline depth of one octave cell
  localparam int CELL_LAT = 7;
  // quotient bits resolved per divider stage
  localparam int DIV_STEP = 4;

  typedef enum logic [1:0] {
    REG_OCTAVES = 2'd0,
    REG_FREQ    = 2'd1,
    REG_SEED    = 2'd2,
    REG_SCALE   = 2'd3
  } fvn_reg_t;

endpackage

// ===== src/fvn_cell.sv =====
`timescale 1ns / 1ps
// One octave cell: lattice split, hashing, fade, bilinear blend, accumulate.
// Depends on fvn_pkg. Cells are chained, each passes coordinates and partial sum on.
module fvn_cell #(
  parameter int OCT         = 0,
  parameter int FRAC_BITS   = fvn_pkg::DEF_FRAC_BITS,
  parameter int MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic [$clog2(MAX_OCTAVES+1)-1:0]     n_eff,
  input  logic [31:0]                          seed,
  input  logic                                 in_valid,
  input  logic signed [fvn_pkg::P_W-1:0]       in_px,
  input  logic signed [fvn_pkg::P_W-1:0]       in_pz,
  input  logic [30+MAX_OCTAVES:0]              in_acc,
  output logic                                 out_valid,
  output logic signed [fvn_pkg::P_W-1:0]       out_px,
  output logic signed [fvn_pkg::P_W-1:0]       out_pz,
  output logic [30+MAX_OCTAVES:0]              out_acc
);
  import fvn_pkg::*;

  localparam int EXT_W = 2*FRAC_BITS + 32;
  localparam int SUM_W = 31 + MAX_OCTAVES;
  localparam logic [31:0] SEED_OFS = 32'(SEED_STEP * OCT);

  logic signed [P_W-1:0] p_in [2];
  logic [31:0]           cell_c [2];
  logic [15:0]           frac_c [2];

  assign p_in[0] = in_px;
  assign p_in[1] = in_pz;

  // floor(p * 2^OCT / 2^(2*FRAC_BITS)): cell is the integer part mod 2^32
  for (genvar ax = 0; ax < 2; ax++) begin : g_ax
    logic signed [EXT_W-1:0] ext;
    logic [EXT_W-1:0]        sh;
    assign ext = EXT_W'(p_in[ax]);
    assign sh  = ext << OCT;
    assign cell_c[ax] = sh[EXT_W-1 -: 32];
    if (FRAC_BITS >= 16) begin : g_tr
      assign frac_c[ax] = sh[2*FRAC_BITS-1 -: 16];
    end else begin : g_zf
      assign frac_c[ax] = {sh[2*FRAC_BITS-1:FRAC_BITS], {(16-FRAC_BITS){1'b0}}};
    end
  end

  // delay lines
  logic                  vld  [CELL_LAT];
  logic signed [P_W-1:0] pxd  [CELL_LAT];
  logic signed [P_W-1:0] pzd  [CELL_LAT];
  logic [SUM_W-1:0]      accd [CELL_LAT-1];

  // stage registers
  logic [31:0]        hx1, hz1, hs1;
  logic [31:0]        fsq1 [2];
  logic [15:0]        f1   [2];
  logic [31:0]        hh2  [4];
  logic [15:0]        t2   [2];
  logic [31:0]        hm3  [4];
  logic [15:0]        t3   [2];
  logic signed [41:0] top4, bot4;
  logic [15:0]        t4z;
  logic [55:0]        mix5;
  logic [31:0]        a6;
  logic [32:0]        s6;
  logic [SUM_W-1:0]   acc7;

  logic [31:0]        hraw [4];
  logic [49:0]        fp   [2];
  logic [23:0]        v    [4];
  logic signed [24:0] d_top, d_bot;
  logic signed [59:0] mix_full;
  logic [8:0]         a2;
  logic [24:0]        tsum;
  logic               corr;
  logic [32:0]        q;
  logic [30:0]        noise;
  logic               active;

  always_comb begin
    hraw[0] = hx1 + hz1 + hs1;
    hraw[1] = hraw[0] + HASH_MUL_X;
    hraw[2] = hraw[0] + HASH_MUL_Z;
    hraw[3] = hraw[0] + HASH_MUL_X + HASH_MUL_Z;
    for (int i = 0; i < 2; i++) begin
      fp[i] = {18'b0, fsq1[i]} * {32'b0, FADE_THREE - {1'b0, f1[i], 1'b0}};
    end
    for (int i = 0; i < 4; i++) begin
      v[i] = hm3[i][23:0] ^ {8'b0, hm3[i][31:16]};
    end
    d_top = $signed({1'b0, v[1]}) - $signed({1'b0, v[0]});
    d_bot = $signed({1'b0, v[3]}) - $signed({1'b0, v[2]});
    mix_full = (60'(top4) <<< 16) + (60'(bot4) - 60'(top4)) * $signed({1'b0, t4z});
    // divide by 2^24-1 by folding the high part back twice
    a2     = s6[32:24];
    tsum   = {16'b0, a2} + {1'b0, s6[23:0]};
    corr   = (tsum >= {1'b0, VALUE_MAX});
    q      = {1'b0, a6} + {24'b0, a2} + {32'b0, corr};
    noise  = q[32:2];
    active = (int'(n_eff) > OCT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELL_LAT; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < CELL_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pxd[0]  <= in_px;
      pzd[0]  <= in_pz;
      accd[0] <= in_acc;
      for (int i = 1; i < CELL_LAT; i++) begin
        pxd[i] <= pxd[i-1];
        pzd[i] <= pzd[i-1];
      end
      for (int i = 1; i < CELL_LAT-1; i++) accd[i] <= accd[i-1];

      hx1 <= cell_c[0] * HASH_MUL_X;
      hz1 <= cell_c[1] * HASH_MUL_Z;
      hs1 <= (seed + SEED_OFS) * HASH_MUL_S;
      for (int i = 0; i < 2; i++) begin
        fsq1[i] <= {16'b0, frac_c[i]} * {16'b0, frac_c[i]};
        f1[i]   <= frac_c[i];
        t2[i]   <= fp[i][47:32];
        t3[i]   <= t2[i];
      end
      for (int i = 0; i < 4; i++) begin
        hh2[i] <= hraw[i] ^ (hraw[i] >> 13);
        hm3[i] <= hh2[i] * HASH_MIX;
      end
      top4 <= $signed({2'b0, v[0], 16'b0}) + d_top * $signed({1'b0, t3[0]});
      bot4 <= $signed({2'b0, v[2], 16'b0}) + d_bot * $signed({1'b0, t3[0]});
      t4z  <= t3[1];
      mix5 <= mix_full[55:0];
      a6   <= mix5[55:24];
      s6   <= {1'b0, mix5[55:24]} + {9'b0, mix5[23:0]};
      acc7 <= active ? {accd[CELL_LAT-2][SUM_W-2:0], 1'b0} + SUM_W'(noise)
                     : accd[CELL_LAT-2];
    end
  end

  assign out_valid = vld[CELL_LAT-1];
  assign out_px    = pxd[CELL_LAT-1];
  assign out_pz    = pzd[CELL_LAT-1];
  assign out_acc   = acc7;

endmodule

// ===== src/fvn_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
// Depends on fvn_pkg. Divides the octave sum by the weight total.
module fvn_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 8,
  parameter int Q_W   = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [DEN_W-1:0] den,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo
);
  import fvn_pkg::*;

  localparam int NS    = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W = NS * DIV_STEP;

  logic [DEN_W-1:0] rem_q [NS];
  logic [PAD_W-1:0] num_q [NS];
  logic             vld_q [NS];
  logic [DEN_W-1:0] rem_s [NS];
  logic [PAD_W-1:0] num_s [NS];
  logic             vld_s [NS];
  logic [DEN_W-1:0] rem_d [NS];
  logic [PAD_W-1:0] num_d [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    if (k == 0) begin : g_first
      assign rem_s[k] = '0;
      assign num_s[k] = PAD_W'(in_num);
      assign vld_s[k] = in_valid;
    end else begin : g_next
      assign rem_s[k] = rem_q[k-1];
      assign num_s[k] = num_q[k-1];
      assign vld_s[k] = vld_q[k-1];
    end

    always_comb begin
      logic [DEN_W:0]   r;
      logic [PAD_W-1:0] nm;
      r  = {1'b0, rem_s[k]};
      nm = num_s[k];
      for (int j = 0; j < DIV_STEP; j++) begin
        r  = {r[DEN_W-1:0], nm[PAD_W-1]};
        nm = {nm[PAD_W-2:0], 1'b0};
        if (r >= {1'b0, den}) begin
          r     = r - {1'b0, den};
          nm[0] = 1'b1;
        end
      end
      rem_d[k] = r[DEN_W-1:0];
      num_d[k] = nm;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= vld_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k] <= rem_d[k];
        num_q[k] <= num_d[k];
      end
    end
  end

  assign out_valid = vld_q[NS-1];
  assign out_quo   = num_q[NS-1][Q_W-1:0];

endmodule

// ===== src/fractal_value_noise_height_core.sv =====
`timescale 1ns / 1ps
// Top level of the fractal value-noise height core: APB registers, front multiply,
// chain of octave cells, divider and output scaling. Depends on fvn_pkg, fvn_cell, fvn_div.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    coord_x, coord_z
//  out       output     out_valid / out_ready  height_out
//  cfg       input      APB psel/penable       paddr, pwdata, prdata
//
// One transaction per cycle unless the output stalls. Results pass the input register,
// the seven-stage octave cell per octave, the divider, and the scaling and output registers.
// Reset is synchronous and clears all valid bits and the registers to their defaults.
// A held result stalls the pipeline only when the last stage also holds a result.
module fractal_value_noise_height_core #(
  parameter int MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES,
  parameter int FRAC_BITS   = fvn_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] height_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import fvn_pkg::*;

  localparam int SUM_W = 31 + MAX_OCTAVES;
  localparam int NW    = $clog2(MAX_OCTAVES + 1);

  logic [3:0]         octave_count;
  logic [FREQ_W-1:0]  base_frequency;
  logic [31:0]        noise_seed;
  logic signed [31:0] height_scale;

  fvn_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = fvn_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count   <= 4'd1;
      base_frequency <= 24'd65536;
      noise_seed     <= '0;
      height_scale   <= 32'sd65536;
    end else if (wr_en) begin
      case (reg_sel)
        REG_OCTAVES: octave_count   <= pwdata[3:0];
        REG_FREQ:    base_frequency <= pwdata[FREQ_W-1:0];
        REG_SEED:    noise_seed     <= pwdata;
        REG_SCALE:   height_scale   <= pwdata;
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OCTAVES: prdata = {28'b0, octave_count};
      REG_FREQ:    prdata = {8'b0, base_frequency};
      REG_SEED:    prdata = noise_seed;
      REG_SCALE:   prdata = height_scale;
      default:     prdata = '0;
    endcase
  end

  // effective octave count and weight total 2^n - 1
  logic [NW-1:0]          n_eff;
  logic [MAX_OCTAVES-1:0] den;

  always_comb begin
    if (octave_count == 4'd0) begin
      n_eff = NW'(1);
    end else if (int'(octave_count) > MAX_OCTAVES) begin
      n_eff = NW'(MAX_OCTAVES);
    end else begin
      n_eff = NW'(octave_count);
    end
    den = MAX_OCTAVES'((32'd1 << n_eff) - 32'd1);
  end

  // pipeline advance: hold only when the last stage and the output are both full
  logic adv;
  logic p_valid;

  assign adv      = !(out_valid && !out_ready && p_valid);
  assign in_ready = adv;

  logic                  c_valid [MAX_OCTAVES+1];
  logic signed [P_W-1:0] c_px    [MAX_OCTAVES+1];
  logic signed [P_W-1:0] c_pz    [MAX_OCTAVES+1];
  logic [SUM_W-1:0]      c_acc   [MAX_OCTAVES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (adv) begin
      c_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_px[0]  <= coord_x * $signed({1'b0, base_frequency});
      c_pz[0]  <= coord_z * $signed({1'b0, base_frequency});
      c_acc[0] <= '0;
    end
  end

  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_cell
    fvn_cell #(
      .OCT         (o),
      .FRAC_BITS   (FRAC_BITS),
      .MAX_OCTAVES (MAX_OCTAVES)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .n_eff     (n_eff),
      .seed      (noise_seed),
      .in_valid  (c_valid[o]),
      .in_px     (c_px[o]),
      .in_pz     (c_pz[o]),
      .in_acc    (c_acc[o]),
      .out_valid (c_valid[o+1]),
      .out_px    (c_px[o+1]),
      .out_pz    (c_pz[o+1]),
      .out_acc   (c_acc[o+1])
    );
  end

  logic        d_valid;
  logic [30:0] m_quo;

  fvn_div #(
    .NUM_W (SUM_W),
    .DEN_W (MAX_OCTAVES),
    .Q_W   (31)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .den       (den),
    .in_valid  (c_valid[MAX_OCTAVES]),
    .in_num    (c_acc[MAX_OCTAVES]),
    .out_valid (d_valid),
    .out_quo   (m_quo)
  );

  // map [0, 2^30] to [-2^30, 2^30] and scale
  logic signed [31:0] t_val;
  logic signed [63:0] prod;
  logic signed [33:0] res;
  logic signed [31:0] sat;

  assign t_val = $signed({m_quo, 1'b0}) - 32'sd1073741824;
  assign res   = prod[63:30];

  always_comb begin
    if (res[33:31] == 3'b000 || res[33:31] == 3'b111) begin
      sat = res[31:0];
    end else if (res[33]) begin
      sat = 32'sh80000000;
    end else begin
      sat = 32'sh7FFFFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= t_val * height_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && p_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && p_valid) begin
      height_out <= sat;
    end
  end

endmodule

// ===== src/fvn_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the fractal value-noise height core, bound to the top level.
// Depends on fvn_pkg for register codes and on the top level's ports.
module fvn_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] height_out,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [3:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);
  import fvn_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(height_out))
    else $error("result changed while stalled");

  // a ready receiver never blocks the input
  a_ready_pass: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled with receiver ready");

  a_octave_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[3:2] == REG_OCTAVES
    |=> (paddr[3:2] != REG_OCTAVES || prdata[3:0] == $past(pwdata[3:0])))
    else $error("octave count readback mismatch");

endmodule

bind fractal_value_noise_height_core fvn_checker u_fvn_checker (.*);
